// File: design/tls_pkg.sv
package tls_pkg;

  localparam int MAX_CELLS_DEF = 8;
  localparam int COLOR_BITS    = 16;
  localparam int MAX_SCALE     = 6;
  localparam int FRAC_BITS     = 6;
  localparam int COORD_BITS    = 10;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic CFG_GRID_CELLS = 1'b0;
  localparam logic CFG_SCALE_LOG2 = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [3:0]            vert_x;
    logic [3:0]            vert_y;
    logic [3:0]            vert_z;
    logic [COLOR_BITS-1:0] vert_red;
    logic [COLOR_BITS-1:0] vert_green;
    logic [COLOR_BITS-1:0] vert_blue;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [COORD_BITS-1:0] point_z;
  } req_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_blue;
  } rsp_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } color_t;

  // Weighted blend of two channel values; a zero fraction passes a straight through.
  function automatic logic [COLOR_BITS-1:0] lerp_ch(input logic [COLOR_BITS-1:0] a,
                                                    input logic [COLOR_BITS-1:0] b,
                                                    input logic [FRAC_BITS-1:0] f,
                                                    input logic [2:0] s);
    logic [FRAC_BITS:0]            w0;
    logic [COLOR_BITS+FRAC_BITS+1:0] t;
    w0 = (7'd1 << s) - {1'b0, f};
    t  = ((COLOR_BITS+FRAC_BITS+2)'(a) * w0) + ((COLOR_BITS+FRAC_BITS+2)'(b) * f);
    t  = t >> s;
    return (f == '0) ? a : t[COLOR_BITS-1:0];
  endfunction

  function automatic color_t lerp_color(input color_t a, input color_t b,
                                        input logic [FRAC_BITS-1:0] f, input logic [2:0] s);
    color_t r;
    r.red   = lerp_ch(a.red, b.red, f, s);
    r.green = lerp_ch(a.green, b.green, f, s);
    r.blue  = lerp_ch(a.blue, b.blue, f, s);
    return r;
  endfunction

endpackage

// File: design/trilinear_lattice_sampler.sv
// Trilinear lattice sampler. Write transactions store one vertex color; sample
// transactions return one interpolated color after the address, bank read, z,
// y and x blend stages, on result for the single cycle in which result_valid
// is high. The block takes one transaction every cycle and busy is always low;
// the receiver cannot stall, so it must take every result in its strobe cycle.
// The rate is set by the eight lattice banks, split by vertex coordinate parity,
// which deliver all eight cell corners with one read port each in the same cycle.
// There is no clearing pass; a vertex must be written before any sample uses it.
// Configuration writes are to be made only while no sample is in flight.
module trilinear_lattice_sampler import tls_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       result_valid,
  output rsp_t       result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int IW = $clog2(MAX_CELLS + 2);
  localparam int H  = (MAX_CELLS + 2) / 2;
  localparam int HW = $clog2(H + 1);
  localparam int BD = H * H * H;
  localparam int AW = $clog2(BD + 1);
  localparam int PW = COORD_BITS + 1;

  function automatic logic [AW-1:0] baddr(input logic [HW-1:0] hx, input logic [HW-1:0] hy,
                                          input logic [HW-1:0] hz);
    return AW'((32'(hx) * H + 32'(hy)) * H + 32'(hz));
  endfunction

  // Configuration registers.
  logic [3:0] grid_cells;
  logic [2:0] scale_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cells <= 4'd8;
      scale_log2 <= 3'd4;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_CELLS) grid_cells <= cfg_data;
      else scale_log2 <= cfg_data[2:0];
    end
  end

  logic [PW-1:0] g_eff;
  logic [2:0]    s_eff;
  always_comb begin
    if (grid_cells == 4'd0) g_eff = PW'(1);
    else if (32'(grid_cells) > MAX_CELLS) g_eff = PW'(MAX_CELLS);
    else g_eff = PW'(grid_cells);
    s_eff = (32'(scale_log2) > MAX_SCALE) ? 3'(MAX_SCALE) : scale_log2;
  end

  assign busy = 1'b0;

  // Stage 1: cell index, fraction and bank addresses.
  logic                  v1, typ1, wen1;
  logic [2:0]            wbank1;
  logic [AW-1:0]         waddr1;
  color_t                wdata1;
  logic [AW-1:0]         raddr1 [8];
  logic [2:0]            par1;
  logic [FRAC_BITS-1:0]  f1 [3];
  logic [2:0]            s1;

  logic [COORD_BITS-1:0] pt [3];
  logic [HW-1:0]         he [3], ho [3];
  logic [2:0]            par_c;
  logic [FRAC_BITS-1:0]  f_c [3];
  logic [AW-1:0]         raddr_c [8];
  logic                  inrange;

  always_comb begin
    logic [PW-1:0] ext, p;
    logic [IW-1:0] i0;
    pt[0] = req.point_x;
    pt[1] = req.point_y;
    pt[2] = req.point_z;
    ext = g_eff << s_eff;
    for (int ax = 0; ax < 3; ax++) begin
      p  = PW'(pt[ax]);
      if (p > ext) p = ext;
      i0 = IW'(p >> s_eff);
      f_c[ax]   = FRAC_BITS'(p & ((PW'(1) << s_eff) - PW'(1)));
      par_c[ax] = i0[0];
      he[ax]    = HW'((i0 + IW'(1)) >> 1);
      ho[ax]    = HW'(i0 >> 1);
    end
    for (int b = 0; b < 8; b++) begin
      raddr_c[b] = baddr(b[2] ? ho[0] : he[0], b[1] ? ho[1] : he[1], b[0] ? ho[2] : he[2]);
    end
    inrange = (32'(req.vert_x) <= MAX_CELLS) && (32'(req.vert_y) <= MAX_CELLS) &&
              (32'(req.vert_z) <= MAX_CELLS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      wen1 <= 1'b0;
    end else begin
      v1   <= start && !busy;
      wen1 <= start && !busy && (req.req_type == REQ_WRITE) && inrange;
    end
    typ1   <= req.req_type;
    wbank1 <= {req.vert_x[0], req.vert_y[0], req.vert_z[0]};
    waddr1 <= baddr(HW'(req.vert_x >> 1), HW'(req.vert_y >> 1), HW'(req.vert_z >> 1));
    wdata1 <= '{red: req.vert_red, green: req.vert_green, blue: req.vert_blue};
    raddr1 <= raddr_c;
    par1   <= par_c;
    f1     <= f_c;
    s1     <= s_eff;
  end

  // Lattice banks: bank {x[0], y[0], z[0]} holds the vertices of that parity.
  color_t                mem [8][BD];
  color_t                rd2 [8];
  logic                  v2;
  logic [2:0]            par2;
  logic [FRAC_BITS-1:0]  f2 [3];
  logic [2:0]            s2;

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      if (wen1 && wbank1 == 3'(b)) mem[b][waddr1] <= wdata1;
      rd2[b] <= mem[b][raddr1[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1 && (typ1 == REQ_SAMPLE);
    par2 <= par1;
    f2   <= f1;
    s2   <= s1;
  end

  // Stage 3: blend along z for the four x,y corner pairs.
  color_t               zl3 [4];
  color_t               zl_c [4];
  logic                 v3;
  logic [FRAC_BITS-1:0] fx3, fy3;
  logic [2:0]           s3;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      zl_c[c] = lerp_color(rd2[{par2[0] ^ c[1], par2[1] ^ c[0], par2[2]}],
                           rd2[{par2[0] ^ c[1], par2[1] ^ c[0], ~par2[2]}], f2[2], s2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    zl3 <= zl_c;
    fx3 <= f2[0];
    fy3 <= f2[1];
    s3  <= s2;
  end

  // Stage 4: blend along y.
  color_t               yl4 [2];
  logic                 v4;
  logic [FRAC_BITS-1:0] fx4;
  logic [2:0]           s4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    yl4[0] <= lerp_color(zl3[0], zl3[1], fy3, s3);
    yl4[1] <= lerp_color(zl3[2], zl3[3], fy3, s3);
    fx4 <= fx3;
    s4  <= s3;
  end

  // Stage 5: blend along x into the output register.
  color_t res_c;
  assign res_c = lerp_color(yl4[0], yl4[1], fx4, s4);

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= v4;
    result <= '{out_red: res_c.red, out_green: res_c.green, out_blue: res_c.blue};
  end

endmodule

// File: design/tls_checker.sv
module tls_checker import tls_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic result_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_from_sample: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && req.req_type == REQ_SAMPLE, 5))
    else $error("result without a sample five cycles earlier");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.req_type == REQ_WRITE) |-> ##5 !result_valid)
    else $error("write transaction produced a result");

endmodule

bind trilinear_lattice_sampler tls_checker u_tls_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .result_valid(result_valid)
);
